@@ rtl/core/calendar_timestamp_difference_core_assert.svh @@
// assertion macros for the calendar timestamp difference rtl
`ifndef CALENDAR_TIMESTAMP_DIFFERENCE_CORE_ASSERT_SVH
`define CALENDAR_TIMESTAMP_DIFFERENCE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CTD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

`define CTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`CTD_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`else

`define CTD_ASSERT(label, clk, rst_n, prop)

`define CTD_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/ctd_pkg.sv @@
`default_nettype none

package ctd_pkg;

	localparam int STAMP_W      = 47;
	localparam int MS_W         = 10;
	localparam int YEAR_W       = 14;
	localparam int FLD_W        = 7;
	localparam int BCD_DIGITS   = 15;
	localparam int BCD_W        = 4 * BCD_DIGITS;
	localparam int DAB_STEP     = 8;
	localparam int DAB_IN_W     = 48;
	localparam int DAB_STAGES   = DAB_IN_W / DAB_STEP;
	localparam int SPLIT_STAGES = DAB_STAGES + 1;

	// one timestamp taken apart into binary fields
	typedef struct packed {
		logic [YEAR_W-1:0] yr;
		logic [FLD_W-1:0]  mo;
		logic [FLD_W-1:0]  dy;
		logic [FLD_W-1:0]  hr;
		logic [FLD_W-1:0]  mi;
		logic [FLD_W-1:0]  se;
		logic [MS_W-1:0]   ms;
		logic              leap;
	} ctd_fields_t;

	// shift-add-3 conversion, several input bits per call, msb first
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd_in,
		input logic [DAB_STEP-1:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int s = 0; s < DAB_STEP; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5)
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], bits[DAB_STEP-1-s]};
		end
		return b;
	endfunction

	function automatic logic [FLD_W-1:0] bcd2bin(input logic [3:0] tens,
		input logic [3:0] units);
		return FLD_W'({tens, 3'b000}) + FLD_W'({tens, 1'b0}) + FLD_W'(units);
	endfunction

	// gregorian rule on the year digits; 100 is a multiple of 4
	function automatic logic leap_bcd(input logic [3:0] d13, input logic [3:0] d12,
		input logic [3:0] d11, input logic [3:0] d10);
		logic m4;
		logic c100;
		logic m400;
		m4   = (2'({d11[0], 1'b0}) + d10[1:0]) == 2'd0;
		c100 = (d11 == 4'd0) && (d10 == 4'd0);
		m400 = (2'({d13[0], 1'b0}) + d12[1:0]) == 2'd0;
		return (m4 && !c100) || (c100 && m400);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ctd_split.sv @@
`default_nettype none

module ctd_split import ctd_pkg::*; (
	input  logic                    clk,
	input  logic [SPLIT_STAGES-1:0] en,
	input  logic [STAMP_W-1:0]      stamp,
	input  logic [MS_W-1:0]         ms,
	output ctd_fields_t             fields
);

	// binary to bcd, one byte of the stamp per stage
	logic [BCD_W-1:0]    bcd_s [DAB_STAGES];
	logic [DAB_IN_W-1:0] bin_s [DAB_STAGES-1];
	logic [MS_W-1:0]     ms_s  [DAB_STAGES];
	logic [DAB_IN_W-1:0] bin_in;
	ctd_fields_t         fld_nx;
	ctd_fields_t         fld_s8;

	assign bin_in = {{(DAB_IN_W-STAMP_W){1'b0}}, stamp};

	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[g]) begin
					bcd_s[g] <= dabble_step('0, bin_in[DAB_IN_W-1 -: DAB_STEP]);
					bin_s[g] <= bin_in << DAB_STEP;
					ms_s[g]  <= ms;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[g]) begin
					bcd_s[g] <= dabble_step(bcd_s[g-1], bin_s[g-1][DAB_IN_W-1 -: DAB_STEP]);
					ms_s[g]  <= ms_s[g-1];
				end
			end
			if (g < DAB_STAGES - 1) begin : g_bin
				always_ff @(posedge clk) begin
					if (en[g])
						bin_s[g] <= bin_s[g-1] << DAB_STEP;
				end
			end
		end
	end

	always_comb begin
		logic [BCD_W-1:0] b;
		b = bcd_s[DAB_STAGES-1];
		fld_nx.yr = YEAR_W'(YEAR_W'(b[56 +: 4]) * YEAR_W'(10000))
			+ YEAR_W'(YEAR_W'(b[52 +: 4]) * YEAR_W'(1000))
			+ YEAR_W'(YEAR_W'(b[48 +: 4]) * YEAR_W'(100))
			+ YEAR_W'(bcd2bin(b[44 +: 4], b[40 +: 4]));
		fld_nx.mo   = bcd2bin(b[36 +: 4], b[32 +: 4]);
		fld_nx.dy   = bcd2bin(b[28 +: 4], b[24 +: 4]);
		fld_nx.hr   = bcd2bin(b[20 +: 4], b[16 +: 4]);
		fld_nx.mi   = bcd2bin(b[12 +: 4], b[8 +: 4]);
		fld_nx.se   = bcd2bin(b[4 +: 4], b[0 +: 4]);
		fld_nx.ms   = ms_s[DAB_STAGES-1];
		fld_nx.leap = leap_bcd(b[52 +: 4], b[48 +: 4], b[44 +: 4], b[40 +: 4]);
	end

	always_ff @(posedge clk) begin
		if (en[SPLIT_STAGES-1])
			fld_s8 <= fld_nx;
	end

	assign fields = fld_s8;

endmodule

`default_nettype wire

@@ rtl/core/calendar_timestamp_difference_core.sv @@
// stages in order: swap, split, field differences, borrows, guard, digit weights, packed sum
// throughput: one item per cycle; a stage holds only while it and all later stages are full
// and m_tready is low
// the stamp split holds a six-stage binary to bcd converter, one byte per stage, per operand
// reset: arst_n clears all stage valid bits at once; data registers are not reset
// after reset all stages are empty, so the block is ready to take an item
`default_nettype none
`include "calendar_timestamp_difference_core_assert.svh"

module calendar_timestamp_difference_core import ctd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// dest_stamp[46:0], dest_ms[56:47], src_stamp[103:57], src_ms[113:104], zero fill
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// diff_years[13:0], diff_months[17:14], diff_days[22:18], diff_hours[27:23],
	// diff_minutes[33:28], diff_seconds[39:34], diff_ms[49:40], diff_packed[96:50], zero fill
	output logic [103:0] m_tdata,
	// is_negative[0]
	output logic         m_tuser
);

	localparam int STG_SWAP = 1;
	localparam int STG_FLD  = STG_SWAP + SPLIT_STAGES;
	localparam int N_STG    = STG_FLD + 5;

	localparam logic [FLD_W-1:0] MO_MAR = 7'd3;
	localparam logic [FLD_W-1:0] MO_MAY = 7'd5;
	localparam logic [FLD_W-1:0] MO_JUL = 7'd7;
	localparam logic [FLD_W-1:0] MO_OCT = 7'd10;
	localparam logic [FLD_W-1:0] MO_DEC = 7'd12;

	typedef struct packed {
		logic        neg;
		logic [13:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mi;
		logic [5:0]  se;
		logic [9:0]  ms;
	} res_t;

	logic [N_STG:1] vld_q;
	logic [N_STG:1] en;

	logic [STAMP_W-1:0] dest_stamp;
	logic [MS_W-1:0]    dest_ms;
	logic [STAMP_W-1:0] src_stamp;
	logic [MS_W-1:0]    src_ms;
	logic               neg_nx;

	logic [STAMP_W-1:0] hi_stamp_s1;
	logic [MS_W-1:0]    hi_ms_s1;
	logic [STAMP_W-1:0] lo_stamp_s1;
	logic [MS_W-1:0]    lo_ms_s1;
	logic               neg_s1;
	logic               neg_s [STG_SWAP+1:STG_FLD];

	ctd_fields_t hi_f;
	ctd_fields_t lo_f;

	logic               neg_s9;
	logic signed [14:0] yr_s9;
	logic signed [7:0]  mo_s9;
	logic signed [8:0]  dy_s9;
	logic signed [8:0]  hr_s9;
	logic signed [8:0]  mi_s9;
	logic signed [8:0]  se_s9;
	logic signed [10:0] ms_s9;
	logic [4:0]         dim_s9;
	logic [4:0]         dim_nx;

	logic               neg_s10;
	logic signed [14:0] yr_s10;
	logic signed [7:0]  mo_s10;
	logic signed [8:0]  dy_s10;
	logic signed [8:0]  hr_s10;
	logic signed [8:0]  mi_s10;
	logic signed [8:0]  se_s10;
	logic signed [10:0] ms_s10;
	logic [4:0]         dim_s10;
	logic signed [8:0]  hr_b;
	logic signed [8:0]  mi_b;
	logic signed [8:0]  se_b;
	logic signed [10:0] ms_b;
	logic signed [8:0]  dy_b;

	res_t res_nx;
	res_t res_s11;
	res_t res_s12;
	res_t res_s13;
	logic [STAMP_W-1:0] p_hi_s12;
	logic [24:0]        p_mid_s12;
	logic [12:0]        p_lo_s12;
	logic [STAMP_W-1:0] pk_s13;

	assign dest_stamp = s_tdata[46:0];
	assign dest_ms    = s_tdata[56:47];
	assign src_stamp  = s_tdata[103:57];
	assign src_ms     = s_tdata[113:104];

	// a stage loads when it is empty or the stage after it moves
	always_comb begin
		en[N_STG] = !vld_q[N_STG] || m_tready;
		for (int k = N_STG - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign s_tready = en[STG_SWAP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= s_tvalid;
			for (int k = 2; k <= N_STG; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: order the operands so later minus earlier is always taken
	assign neg_nx = (dest_stamp < src_stamp) || ((dest_stamp == src_stamp) && (dest_ms < src_ms));

	always_ff @(posedge clk) begin
		if (en[STG_SWAP]) begin
			neg_s1      <= neg_nx;
			hi_stamp_s1 <= neg_nx ? src_stamp : dest_stamp;
			hi_ms_s1    <= neg_nx ? src_ms : dest_ms;
			lo_stamp_s1 <= neg_nx ? dest_stamp : src_stamp;
			lo_ms_s1    <= neg_nx ? dest_ms : src_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (en[STG_SWAP+1])
			neg_s[STG_SWAP+1] <= neg_s1;
		for (int k = STG_SWAP + 2; k <= STG_FLD; k++) begin
			if (en[k])
				neg_s[k] <= neg_s[k-1];
		end
	end

	ctd_split u_split_hi (
		.clk    (clk),
		.en     (en[STG_FLD:STG_SWAP+1]),
		.stamp  (hi_stamp_s1),
		.ms     (hi_ms_s1),
		.fields (hi_f)
	);

	ctd_split u_split_lo (
		.clk    (clk),
		.en     (en[STG_FLD:STG_SWAP+1]),
		.stamp  (lo_stamp_s1),
		.ms     (lo_ms_s1),
		.fields (lo_f)
	);

	// length of the month before the later date's month; january borrows december
	always_comb begin
		if (hi_f.mo == MO_MAR)
			dim_nx = hi_f.leap ? 5'd29 : 5'd28;
		else if (hi_f.mo inside {MO_MAY, MO_JUL, MO_OCT, MO_DEC})
			dim_nx = 5'd30;
		else
			dim_nx = 5'd31;
	end

	always_ff @(posedge clk) begin
		if (en[STG_FLD+1]) begin
			neg_s9 <= neg_s[STG_FLD];
			yr_s9  <= $signed({1'b0, hi_f.yr}) - $signed({1'b0, lo_f.yr});
			mo_s9  <= $signed({1'b0, hi_f.mo}) - $signed({1'b0, lo_f.mo});
			dy_s9  <= $signed({2'b0, hi_f.dy}) - $signed({2'b0, lo_f.dy});
			hr_s9  <= $signed({2'b0, hi_f.hr}) - $signed({2'b0, lo_f.hr});
			mi_s9  <= $signed({2'b0, hi_f.mi}) - $signed({2'b0, lo_f.mi});
			se_s9  <= $signed({2'b0, hi_f.se}) - $signed({2'b0, lo_f.se});
			ms_s9  <= $signed({1'b0, hi_f.ms}) - $signed({1'b0, lo_f.ms});
			dim_s9 <= dim_nx;
		end
	end

	// borrow chain from milliseconds up to the day
	always_comb begin
		ms_b = ms_s9;
		se_b = se_s9;
		mi_b = mi_s9;
		hr_b = hr_s9;
		dy_b = dy_s9;
		if (ms_b < 0) begin
			ms_b = ms_b + 11'sd1000;
			se_b = se_b - 9'sd1;
		end
		if (se_b < 0) begin
			se_b = se_b + 9'sd60;
			mi_b = mi_b - 9'sd1;
		end
		if (mi_b < 0) begin
			mi_b = mi_b + 9'sd60;
			hr_b = hr_b - 9'sd1;
		end
		if (hr_b < 0) begin
			hr_b = hr_b + 9'sd24;
			dy_b = dy_b - 9'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[STG_FLD+2]) begin
			neg_s10 <= neg_s9;
			yr_s10  <= yr_s9;
			mo_s10  <= mo_s9;
			dy_s10  <= dy_b;
			hr_s10  <= hr_b;
			mi_s10  <= mi_b;
			se_s10  <= se_b;
			ms_s10  <= ms_b;
			dim_s10 <= dim_s9;
		end
	end

	// day and month borrows, then the out-of-range guard
	always_comb begin
		logic signed [8:0]  d;
		logic signed [7:0]  mo;
		logic signed [14:0] y;
		logic               bad;
		d  = dy_s10;
		mo = mo_s10;
		y  = yr_s10;
		if (d < 0) begin
			mo = mo - 8'sd1;
			d  = d + $signed({4'b0, dim_s10});
			if (d < 0)
				d = '0;
		end
		if (mo < 0) begin
			y  = y - 15'sd1;
			mo = mo + 8'sd12;
		end
		bad = (y < 0) || (mo < 0) || (hr_s10 < 0) || (mi_s10 < 0) || (se_s10 < 0)
			|| (ms_s10 < 0);
		res_nx.neg = neg_s10;
		res_nx.yr  = bad ? '0 : y[13:0];
		res_nx.mo  = bad ? '0 : mo[3:0];
		res_nx.dy  = bad ? '0 : d[4:0];
		res_nx.hr  = bad ? '0 : hr_s10[4:0];
		res_nx.mi  = bad ? '0 : mi_s10[5:0];
		res_nx.se  = bad ? '0 : se_s10[5:0];
		res_nx.ms  = bad ? '0 : ms_s10[9:0];
	end

	always_ff @(posedge clk) begin
		if (en[STG_FLD+3])
			res_s11 <= res_nx;
	end

	// digit weights of the packed form, summed in the last stage
	always_ff @(posedge clk) begin
		if (en[STG_FLD+4]) begin
			res_s12   <= res_s11;
			p_hi_s12  <= {33'd0, res_s11.yr} * 47'd10000000000
				+ {43'd0, res_s11.mo} * 47'd100000000;
			p_mid_s12 <= 25'(res_s11.dy) * 25'd1000000 + 25'(res_s11.hr) * 25'd10000;
			p_lo_s12  <= 13'(res_s11.mi) * 13'd100 + 13'(res_s11.se);
		end
	end

	always_ff @(posedge clk) begin
		if (en[N_STG]) begin
			res_s13 <= res_s12;
			pk_s13  <= p_hi_s12 + STAMP_W'(p_mid_s12) + STAMP_W'(p_lo_s12);
		end
	end

	assign m_tvalid = vld_q[N_STG];
	assign m_tuser  = res_s13.neg;
	assign m_tdata  = {7'd0, pk_s13, res_s13.ms, res_s13.se, res_s13.mi, res_s13.hr,
		res_s13.dy, res_s13.mo, res_s13.yr};

	`CTD_ASSERT_IMPL(a_ready_follows_sink, clk, arst_n, m_tready, s_tready)
	`CTD_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !s_tready,
		(&vld_q) && !m_tready)
	`CTD_ASSERT_IMPL(a_packed_seconds_only, clk, arst_n,
		m_tvalid && (res_s13.yr == 14'd0) && (res_s13.mo == 4'd0) && (res_s13.dy == 5'd0)
		&& (res_s13.hr == 5'd0) && (res_s13.mi == 6'd0),
		pk_s13 == STAMP_W'(res_s13.se))

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top import ctd_pkg::*;;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 30;
	localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = '1;
	localparam logic [MS_W-1:0]    MS_ALL_ONES    = '1;

	typedef struct {
		longint yr, mo, dy, hr, mi, se, ms;
	} stamp_parts_t;

	typedef struct {
		logic              neg;
		logic [YEAR_W-1:0] yrs;
		logic [3:0]        mons;
		logic [4:0]        days;
		logic [4:0]        hrs;
		logic [5:0]        mins;
		logic [5:0]        secs;
		logic [MS_W-1:0]   msec;
		logic [STAMP_W-1:0] digits;
	} stamp_diff_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// dest_stamp, dest_ms, src_stamp, src_ms, zero fill
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// diff_years, diff_months, diff_days, diff_hours, diff_minutes, diff_seconds,
	// diff_ms, diff_packed, zero fill
	logic [103:0] m_tdata;
	// is_negative
	logic         m_tuser;

	stamp_diff_t expected_diffs[$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	calendar_timestamp_difference_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic stamp_parts_t split_parts(input logic [STAMP_W-1:0] st,
		input logic [MS_W-1:0] ms);
		stamp_parts_t p;
		longint v;
		v = longint'({17'd0, st});
		p.yr = v / 64'sd10000000000;
		p.mo = (v / 64'sd100000000) % 64'sd100;
		p.dy = (v / 64'sd1000000) % 64'sd100;
		p.hr = (v / 64'sd10000) % 64'sd100;
		p.mi = (v / 64'sd100) % 64'sd100;
		p.se = v % 64'sd100;
		p.ms = longint'({54'd0, ms});
		return p;
	endfunction

	// length of the month before mo; anything outside 2..12 falls back to 31
	function automatic longint prior_month_days(input longint yr, input longint mo);
		longint pm;
		pm = mo - 1;
		if (pm == 4 || pm == 6 || pm == 9 || pm == 11)
			return 30;
		if (pm == 2)
			return (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 29 : 28;
		return 31;
	endfunction

	function automatic stamp_diff_t predict_diff(input logic [STAMP_W-1:0] ds,
		input logic [MS_W-1:0] dm, input logic [STAMP_W-1:0] ss, input logic [MS_W-1:0] sm);
		stamp_parts_t hi, lo;
		longint y, mo, d, h, mi, s, ms;
		longint unsigned pk;
		stamp_diff_t r;
		r.neg = (ds < ss) || (ds == ss && dm < sm);
		// later minus earlier, fields never negated
		if (r.neg) begin
			hi = split_parts(ss, sm);
			lo = split_parts(ds, dm);
		end else begin
			hi = split_parts(ds, dm);
			lo = split_parts(ss, sm);
		end
		y  = hi.yr - lo.yr;
		mo = hi.mo - lo.mo;
		d  = hi.dy - lo.dy;
		h  = hi.hr - lo.hr;
		mi = hi.mi - lo.mi;
		s  = hi.se - lo.se;
		ms = hi.ms - lo.ms;
		if (ms < 0) begin
			s--;
			ms += 1000;
		end
		if (s < 0) begin
			mi--;
			s += 60;
		end
		if (mi < 0) begin
			h--;
			mi += 60;
		end
		if (h < 0) begin
			d--;
			h += 24;
		end
		if (d < 0) begin
			mo--;
			d += prior_month_days(hi.yr, hi.mo);
			if (d < 0)
				d = 0;
		end
		if (mo < 0) begin
			y--;
			mo += 12;
		end
		if (y < 0 || mo < 0 || h < 0 || mi < 0 || s < 0 || ms < 0) begin
			y = 0;
			mo = 0;
			d = 0;
			h = 0;
			mi = 0;
			s = 0;
			ms = 0;
		end
		r.yrs  = y[YEAR_W-1:0];
		r.mons = mo[3:0];
		r.days = d[4:0];
		r.hrs  = h[4:0];
		r.mins = mi[5:0];
		r.secs = s[5:0];
		r.msec = ms[MS_W-1:0];
		pk = r.yrs * 64'd10000000000 + r.mons * 64'd100000000 + r.days * 64'd1000000
			+ r.hrs * 64'd10000 + r.mins * 64'd100 + r.secs;
		r.digits = pk[STAMP_W-1:0];
		return r;
	endfunction

	function automatic logic [STAMP_W-1:0] make_stamp(input int yr, input int mo, input int dy,
		input int hr, input int mi, input int se);
		longint v;
		v = yr * 64'sd10000000000 + mo * 64'sd100000000 + dy * 64'sd1000000
			+ hr * 64'sd10000 + mi * 64'sd100 + se;
		return v[STAMP_W-1:0];
	endfunction

	function automatic logic [STAMP_W-1:0] rand_stamp();
		int yr;
		yr = ($urandom_range(3) == 0) ? 100 * $urandom_range(99) : $urandom_range(9999);
		return make_stamp(yr, $urandom_range(1, 12), $urandom_range(1, 31),
			$urandom_range(23), $urandom_range(59), $urandom_range(59));
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [STAMP_W-1:0] ds, input logic [MS_W-1:0] dm,
		input logic [STAMP_W-1:0] ss, input logic [MS_W-1:0] sm);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, sm, ss, dm, ds};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_diffs.push_back(predict_diff(ds, dm, ss, sm));
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : result_check
		stamp_diff_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_diffs.size() == 0) begin
				$error("result item with no item pending");
				errors++;
			end else begin
				want = expected_diffs.pop_front();
				check_field("is_negative", want.neg, m_tuser);
				check_field("diff_years", want.yrs, m_tdata[13:0]);
				check_field("diff_months", want.mons, m_tdata[17:14]);
				check_field("diff_days", want.days, m_tdata[22:18]);
				check_field("diff_hours", want.hrs, m_tdata[27:23]);
				check_field("diff_minutes", want.mins, m_tdata[33:28]);
				check_field("diff_seconds", want.secs, m_tdata[39:34]);
				check_field("diff_ms", want.msec, m_tdata[49:40]);
				check_field("diff_packed", want.digits, m_tdata[96:50]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic test_extremes();
		send_item('0, '0, '0, '0);
		send_item(STAMP_ALL_ONES, MS_ALL_ONES, '0, '0);
		send_item('0, '0, STAMP_ALL_ONES, MS_ALL_ONES);
		send_item(STAMP_ALL_ONES, MS_ALL_ONES, STAMP_ALL_ONES, MS_ALL_ONES);
		send_item(make_stamp(9999, 12, 31, 23, 59, 59), 10'd999, '0, '0);
		// equal stamps, milliseconds decide the sign
		send_item(make_stamp(2023, 6, 15, 12, 0, 0), 10'd5,
			make_stamp(2023, 6, 15, 12, 0, 0), 10'd900);
		send_item(make_stamp(2023, 6, 15, 12, 0, 0), 10'd900,
			make_stamp(2023, 6, 15, 12, 0, 0), 10'd5);
		// milliseconds past 999 pass through without carry
		send_item(make_stamp(2023, 6, 15, 12, 0, 0), MS_ALL_ONES,
			make_stamp(2023, 6, 15, 11, 59, 59), 10'd0);
	endtask

	task automatic test_borrow_chain();
		// january borrows december
		send_item(make_stamp(2021, 1, 5, 0, 0, 0), 10'd0,
			make_stamp(2020, 12, 20, 0, 0, 0), 10'd0);
		send_item(make_stamp(2024, 1, 1, 0, 0, 0), 10'd0,
			make_stamp(2023, 12, 31, 23, 59, 59), 10'd999);
		send_item(make_stamp(2023, 12, 31, 23, 59, 59), 10'd999,
			make_stamp(2024, 1, 1, 0, 0, 0), 10'd0);
		send_item(make_stamp(2023, 5, 1, 6, 0, 0), 10'd0,
			make_stamp(2023, 4, 30, 18, 30, 0), 10'd250);
	endtask

	task automatic test_leap_years();
		send_item(make_stamp(2024, 3, 1, 0, 0, 0), 10'd0,
			make_stamp(2024, 2, 28, 12, 0, 0), 10'd0);
		send_item(make_stamp(1900, 3, 1, 0, 0, 0), 10'd0,
			make_stamp(1900, 2, 27, 0, 0, 0), 10'd0);
		send_item(make_stamp(2000, 3, 1, 0, 0, 0), 10'd0,
			make_stamp(2000, 2, 27, 0, 0, 0), 10'd0);
		send_item(make_stamp(2023, 3, 1, 0, 0, 0), 10'd0,
			make_stamp(2023, 2, 27, 0, 0, 0), 10'd0);
	endtask

	task automatic test_malformed_fields();
		// day still negative after the borrow, clamps to zero
		send_item(make_stamp(2023, 5, 0, 12, 0, 0), 10'd0,
			make_stamp(2023, 4, 31, 0, 0, 0), 10'd0);
		// month 13 and month 0 borrow 31 days
		send_item(make_stamp(2023, 13, 1, 0, 0, 0), 10'd0,
			make_stamp(2023, 12, 15, 0, 0, 0), 10'd0);
		send_item(make_stamp(2024, 0, 5, 0, 0, 0), 10'd0,
			make_stamp(2023, 1, 10, 0, 0, 0), 10'd0);
		// month and hour left negative zero every field
		send_item(make_stamp(2000, 5, 1, 0, 0, 0), 10'd0,
			make_stamp(1999, 99, 1, 0, 0, 0), 10'd0);
		send_item(make_stamp(2023, 1, 2, 0, 0, 0), 10'd0,
			make_stamp(2023, 1, 1, 99, 0, 0), 10'd0);
		// digits wider than their fields get cut
		send_item(make_stamp(2023, 1, 1, 99, 99, 99), 10'd0,
			make_stamp(2023, 1, 1, 0, 0, 0), 10'd0);
	endtask

	// mostly legal pairs placed to hit borrows, the rest raw bit patterns
	task automatic test_random(input int count);
		logic [STAMP_W-1:0] a, b, t;
		logic [MS_W-1:0]    am, bm, tm;
		int                 pick, y, mo, dy;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			y    = ($urandom_range(3) == 0) ? 100 * $urandom_range(1, 99)
				: $urandom_range(1, 9999);
			mo   = $urandom_range(1, 12);
			dy   = $urandom_range(1, 31);
			am   = MS_W'($urandom_range(999));
			bm   = MS_W'($urandom_range(999));
			a    = rand_stamp();
			b    = rand_stamp();
			if (pick < 25) begin
				// independent stamps
			end else if (pick < 45) begin
				a = make_stamp(y, mo, $urandom_range(1, 31), $urandom_range(23),
					$urandom_range(59), $urandom_range(59));
				b = make_stamp(y, mo, $urandom_range(1, 31), $urandom_range(23),
					$urandom_range(59), $urandom_range(59));
			end else if (pick < 60) begin
				b = a;
			end else if (pick < 80) begin
				// early in a month against late in the month before
				a = make_stamp(y, mo, $urandom_range(1, 3), $urandom_range(23),
					$urandom_range(59), $urandom_range(59));
				if (mo == 1)
					b = make_stamp(y - 1, 12, $urandom_range(25, 31), $urandom_range(23),
						$urandom_range(59), $urandom_range(59));
				else
					b = make_stamp(y, mo - 1, $urandom_range(25, 31), $urandom_range(23),
						$urandom_range(59), $urandom_range(59));
			end else if (pick < 88) begin
				a = make_stamp(y, mo, dy, $urandom_range(23), $urandom_range(59),
					$urandom_range(59));
				b = make_stamp(y, mo, dy, $urandom_range(23), $urandom_range(59),
					$urandom_range(59));
			end else begin
				a  = STAMP_W'({$urandom, $urandom});
				b  = STAMP_W'({$urandom, $urandom});
				am = MS_W'($urandom_range(1023));
				bm = MS_W'($urandom_range(1023));
			end
			if ($urandom_range(1) == 1) begin
				t  = a;
				a  = b;
				b  = t;
				tm = am;
				am = bm;
				bm = tm;
			end
			send_item(a, am, b, bm);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_borrow_chain();
		test_leap_years();
		test_malformed_fields();

		test_random(500);
		send_idle_pct = 86;
		test_random(400);
		send_idle_pct = 0;
		stall_pct     = 86;
		test_random(400);
		send_idle_pct = 10;
		stall_pct     = 10;
		test_random(400);

		s_tvalid <= 1'b0;
		while (expected_diffs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
